// ===== hw/rtl/fpp_pkg.sv =====
// Shared types, constants and helper functions of the fisheye point projector.
`timescale 1ns / 1ps
package fpp_pkg;

    // Pipeline geometry
    localparam int SQRT_STEPS   = 32;
    localparam int ANGLE_STEPS  = 28;
    localparam int DIV_STEPS    = 31;
    localparam int CORDIC_W     = 51;

    // Fixed-point constants
    localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] Q28_ONE     = 32'sd268435456;
    localparam logic signed [63:0] LIM_POS     = 64'sd2305843009213693952;
    localparam logic signed [63:0] LIM_NEG     = -64'sd2305843009213693952;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_K1  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_K2  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_K3  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_K4  = 4'd7;

    // One point in flight, as it moves down the pipeline
    typedef struct packed {
        logic [31:0]          x;
        logic [31:0]          y;
        logic [31:0]          z;
        logic [63:0]          rad;
        logic [34:0]          rem;
        logic [31:0]          root;
        logic                 on_axis;
        logic [CORDIC_W-1:0]  cx;
        logic [CORDIC_W-1:0]  cy;
        logic [31:0]          ang;
        logic [31:0]          remx;
        logic [31:0]          remy;
        logic [30:0]          qx;
        logic [30:0]          qy;
        logic [29:0]          theta;
        logic [63:0]          t2;
        logic [63:0]          p;
        logic [63:0]          dt;
    } t_item;

    // Arctangent of 2^-i in Q4.28
    function automatic logic signed [31:0] f_atan(input int i);
        logic signed [31:0] v;
        case (i)
            0:       v = 32'sd210828714;
            1:       v = 32'sd124459457;
            2:       v = 32'sd65760959;
            3:       v = 32'sd33381290;
            4:       v = 32'sd16755422;
            5:       v = 32'sd8385879;
            6:       v = 32'sd4193963;
            7:       v = 32'sd2097109;
            8:       v = 32'sd1048571;
            9:       v = 32'sd524287;
            default: v = 32'sd1 <<< (28 - i);
        endcase
        return v;
    endfunction

    // Limit to +-2^61
    function automatic logic signed [63:0] f_clamp(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > LIM_POS) begin
            r = LIM_POS;
        end else if (v < LIM_NEG) begin
            r = LIM_NEG;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic [31:0] f_sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/fisheye_point_projection_core.sv =====
// Top level of the fisheye point projector: config registers, cell chains, output queue.
// Pipeline: 1 square stage, 32 root cells, 31 angle/divide cells and 8 chained
//   multiply cells of 3 stages each, then the two-entry output queue.
// Throughput: one point per cycle; the input stalls only while two results wait.
// Reset (synchronous, active low): empties the pipeline and the two-entry output
//   queue and loads the configuration registers with their default values.
`timescale 1ns / 1ps
module fisheye_point_projection_core import fpp_pkg::*; #(
    parameter int MIN_RADIUS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // input points
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [95:0]          s_axis_tdata,  // point_x, point_y, point_z
    // output pixels
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // pixel_u, pixel_v
    output logic [0:0]           m_axis_tuser   // on_axis
);

    // ---------------- configuration ----------------
    logic [30:0]        r_focal_x, r_focal_y;
    logic signed [31:0] r_center_x, r_center_y;
    logic signed [31:0] r_k1, r_k2, r_k3, r_k4;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 31'd32768000;
            r_focal_y  <= 31'd32768000;
            r_center_x <= 32'sd20971520;
            r_center_y <= 32'sd15728640;
            r_k1       <= '0;
            r_k2       <= '0;
            r_k3       <= '0;
            r_k4       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data[30:0];
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data[30:0];
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                CFG_DIST_K1:  r_k1       <= i_cfg_data;
                CFG_DIST_K2:  r_k2       <= i_cfg_data;
                CFG_DIST_K3:  r_k3       <= i_cfg_data;
                CFG_DIST_K4:  r_k4       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic [1:0] r_count;
    logic       w_en;

    assign w_en          = (r_count != 2'd2);
    assign s_axis_tready = w_en;

    // ---------------- square stage ----------------
    logic        r_fr_valid;
    logic [31:0] r_fr_x, r_fr_y, r_fr_z;
    logic [63:0] r_sqx, r_sqy;
    logic [31:0] w_ax, w_ay;

    assign w_ax = s_axis_tdata[31]  ? 32'(-s_axis_tdata[31:0])  : s_axis_tdata[31:0];
    assign w_ay = s_axis_tdata[63]  ? 32'(-s_axis_tdata[63:32]) : s_axis_tdata[63:32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_valid <= 1'b0;
        end else if (w_en) begin
            r_fr_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fr_x <= s_axis_tdata[31:0];
            r_fr_y <= s_axis_tdata[63:32];
            r_fr_z <= s_axis_tdata[95:64];
            r_sqx  <= 64'(w_ax) * 64'(w_ax);
            r_sqy  <= 64'(w_ay) * 64'(w_ay);
        end
    end

    // ---------------- square root chain ----------------
    t_item sq_item [0:SQRT_STEPS];
    logic  sq_vld  [0:SQRT_STEPS];

    always_comb begin
        sq_item[0]      = '0;
        sq_item[0].x    = r_fr_x;
        sq_item[0].y    = r_fr_y;
        sq_item[0].z    = r_fr_z;
        sq_item[0].rad  = r_sqx + r_sqy;
    end
    assign sq_vld[0] = r_fr_valid;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        fpp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (sq_vld[g]),
            .i_item  (sq_item[g]),
            .o_valid (sq_vld[g+1]),
            .o_item  (sq_item[g+1])
        );
    end

    // ---------------- angle and ratio chain ----------------
    t_item cd_item [0:DIV_STEPS];
    logic  cd_vld  [0:DIV_STEPS];
    logic signed [CORDIC_W-1:0] w_rc, w_zc;
    logic [31:0] w_mx, w_my;

    // Seed the CORDIC vector and both divider remainders
    always_comb begin
        cd_item[0]         = sq_item[SQRT_STEPS];
        w_rc               = $signed({19'd0, sq_item[SQRT_STEPS].root});
        w_zc               = CORDIC_W'($signed(sq_item[SQRT_STEPS].z));
        w_mx = sq_item[SQRT_STEPS].x[31] ? 32'(-sq_item[SQRT_STEPS].x) : sq_item[SQRT_STEPS].x;
        w_my = sq_item[SQRT_STEPS].y[31] ? 32'(-sq_item[SQRT_STEPS].y) : sq_item[SQRT_STEPS].y;
        cd_item[0].on_axis = (sq_item[SQRT_STEPS].root <= 32'(MIN_RADIUS));
        if (sq_item[SQRT_STEPS].z[31]) begin
            cd_item[0].cx  = w_rc <<< 16;
            cd_item[0].cy  = (-w_zc) <<< 16;
            cd_item[0].ang = HALF_PI_Q28;
        end else begin
            cd_item[0].cx  = w_zc <<< 16;
            cd_item[0].cy  = w_rc <<< 16;
            cd_item[0].ang = '0;
        end
        cd_item[0].remx = {1'b0, w_mx[31:1]};
        cd_item[0].remy = {1'b0, w_my[31:1]};
        cd_item[0].qx   = '0;
        cd_item[0].qy   = '0;
    end
    assign cd_vld[0] = sq_vld[SQRT_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_angle
        fpp_angle_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (cd_vld[g]),
            .i_item  (cd_item[g]),
            .o_valid (cd_vld[g+1]),
            .o_item  (cd_item[g+1])
        );
    end

    // ---------------- multiply chain ----------------
    t_item m_in_t2, m_out_t2, m_in_p3, m_out_p3, m_in_p2, m_out_p2;
    t_item m_in_p1, m_out_p1, m_in_p0, m_out_p0, m_in_dt, m_out_dt;
    t_item m_out_fx, m_out_u;
    logic  v_t2, v_p3, v_p2, v_p1, v_p0, v_dt, v_fx, v_u;
    logic signed [63:0] res_t2, res_p3, res_p2, res_p1, res_p0, res_dt;
    logic signed [63:0] res_fx, res_fy, res_u, res_v;
    logic signed [31:0] w_ang_end;
    logic signed [32:0] w_theta_n;
    logic signed [32:0] w_qx_s, w_qy_s;

    // Clamp the angle to [0, pi]
    always_comb begin
        m_in_t2   = cd_item[DIV_STEPS];
        w_ang_end = $signed(cd_item[DIV_STEPS].ang);
        if (w_ang_end < 0) begin
            m_in_t2.theta = '0;
        end else if (w_ang_end > PI_Q28) begin
            m_in_t2.theta = PI_Q28[29:0];
        end else begin
            m_in_t2.theta = w_ang_end[29:0];
        end
    end
    assign w_theta_n = $signed({3'b000, m_in_t2.theta});

    fpp_mul_cell #(.SHIFT(28)) u_mul_t2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(cd_vld[DIV_STEPS]),
        .i_item(m_in_t2), .i_wide($signed({34'd0, m_in_t2.theta})), .i_narrow(w_theta_n),
        .i_add(32'sd0), .o_valid(v_t2), .o_item(m_out_t2), .o_res(res_t2)
    );

    always_comb begin
        m_in_p3    = m_out_t2;
        m_in_p3.t2 = res_t2;
    end

    fpp_mul_cell #(.SHIFT(28)) u_mul_p3 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_t2),
        .i_item(m_in_p3), .i_wide(64'(r_k4)), .i_narrow($signed(m_in_p3.t2[32:0])),
        .i_add(r_k3), .o_valid(v_p3), .o_item(m_out_p3), .o_res(res_p3)
    );

    always_comb begin
        m_in_p2   = m_out_p3;
        m_in_p2.p = res_p3;
    end

    fpp_mul_cell #(.SHIFT(28)) u_mul_p2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_p3),
        .i_item(m_in_p2), .i_wide($signed(m_in_p2.p)), .i_narrow($signed(m_in_p2.t2[32:0])),
        .i_add(r_k2), .o_valid(v_p2), .o_item(m_out_p2), .o_res(res_p2)
    );

    always_comb begin
        m_in_p1   = m_out_p2;
        m_in_p1.p = res_p2;
    end

    fpp_mul_cell #(.SHIFT(28)) u_mul_p1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_p2),
        .i_item(m_in_p1), .i_wide($signed(m_in_p1.p)), .i_narrow($signed(m_in_p1.t2[32:0])),
        .i_add(r_k1), .o_valid(v_p1), .o_item(m_out_p1), .o_res(res_p1)
    );

    always_comb begin
        m_in_p0   = m_out_p1;
        m_in_p0.p = res_p1;
    end

    fpp_mul_cell #(.SHIFT(28)) u_mul_p0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_p1),
        .i_item(m_in_p0), .i_wide($signed(m_in_p0.p)), .i_narrow($signed(m_in_p0.t2[32:0])),
        .i_add(Q28_ONE), .o_valid(v_p0), .o_item(m_out_p0), .o_res(res_p0)
    );

    always_comb begin
        m_in_dt   = m_out_p0;
        m_in_dt.p = res_p0;
    end

    fpp_mul_cell #(.SHIFT(28)) u_mul_dt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_p0),
        .i_item(m_in_dt), .i_wide($signed(m_in_dt.p)),
        .i_narrow($signed({3'b000, m_in_dt.theta})),
        .i_add(32'sd0), .o_valid(v_dt), .o_item(m_out_dt), .o_res(res_dt)
    );

    // Focal scaling, one lane per axis
    fpp_mul_cell #(.SHIFT(28)) u_mul_fx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_dt),
        .i_item(m_out_dt), .i_wide(res_dt), .i_narrow($signed({2'b00, r_focal_x})),
        .i_add(32'sd0), .o_valid(v_fx), .o_item(m_out_fx), .o_res(res_fx)
    );

    fpp_mul_cell #(.SHIFT(28)) u_mul_fy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_dt),
        .i_item(m_out_dt), .i_wide(res_dt), .i_narrow($signed({2'b00, r_focal_y})),
        .i_add(32'sd0), .o_valid(), .o_item(), .o_res(res_fy)
    );

    // Signed unit-vector components in Q2.30
    assign w_qx_s = m_out_fx.x[31] ? -$signed({2'b00, m_out_fx.qx}) : $signed({2'b00, m_out_fx.qx});
    assign w_qy_s = m_out_fx.y[31] ? -$signed({2'b00, m_out_fx.qy}) : $signed({2'b00, m_out_fx.qy});

    fpp_mul_cell #(.SHIFT(30)) u_mul_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_fx),
        .i_item(m_out_fx), .i_wide(res_fx), .i_narrow(w_qx_s),
        .i_add(r_center_x), .o_valid(v_u), .o_item(m_out_u), .o_res(res_u)
    );

    fpp_mul_cell #(.SHIFT(30)) u_mul_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(v_fx),
        .i_item(m_out_fx), .i_wide(res_fy), .i_narrow(w_qy_s),
        .i_add(r_center_y), .o_valid(), .o_item(), .o_res(res_v)
    );

    // ---------------- output queue ----------------
    logic [64:0] w_result;
    logic [64:0] r_head, r_skid;
    logic        w_push, w_pop;

    always_comb begin
        if (m_out_u.on_axis) begin
            w_result = {1'b1, r_center_y, r_center_x};
        end else begin
            w_result = {1'b0, f_sat32(res_v), f_sat32(res_u)};
        end
    end

    assign w_push = w_en && v_u;
    assign w_pop  = m_axis_tvalid && m_axis_tready;

    // Two-entry queue: head drives the port, skid catches one more result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            case (r_count)
                2'd0:    r_count <= w_push ? 2'd1 : 2'd0;
                2'd1:    r_count <= (w_push && !w_pop) ? 2'd2 :
                                    (!w_push && w_pop) ? 2'd0 : 2'd1;
                2'd2:    r_count <= w_pop ? 2'd1 : 2'd2;
                default: r_count <= 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_count)
            2'd0: begin
                if (w_push) begin
                    r_head <= w_result;
                end
            end
            2'd1: begin
                if (w_push && w_pop) begin
                    r_head <= w_result;
                end else if (w_push) begin
                    r_skid <= w_result;
                end
            end
            2'd2: begin
                if (w_pop) begin
                    r_head <= r_skid;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = (r_count != 2'd0);
    assign m_axis_tdata  = r_head[63:0];
    assign m_axis_tuser  = r_head[64];

endmodule

// ===== hw/rtl/fpp_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
`timescale 1ns / 1ps
module fpp_sqrt_cell import fpp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic [34:0] w_cur;
    logic [34:0] w_trial;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        n_item  = i_item;
        w_cur   = {i_item.rem[32:0], i_item.rad[63:62]};
        w_trial = {1'b0, i_item.root, 2'b01};
        n_item.rad = {i_item.rad[61:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_item.rem  = w_cur - w_trial;
            n_item.root = {i_item.root[30:0], 1'b1};
        end else begin
            n_item.rem  = w_cur;
            n_item.root = {i_item.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/fpp_angle_cell.sv =====
// One cell of the angle and ratio chain: a CORDIC step (only in cells below ANGLE_STEPS) and a quotient bit per axis.
`timescale 1ns / 1ps
module fpp_angle_cell import fpp_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    localparam logic signed [31:0] ATAN = f_atan(STEP);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic signed [CORDIC_W-1:0] w_x;
    logic signed [CORDIC_W-1:0] w_y;
    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [31:0]         w_ang;
    logic                       w_bx;
    logic                       w_by;
    logic [32:0]                w_tx;
    logic [32:0]                w_ty;

    always_comb begin
        n_item = i_item;
        w_x    = $signed(i_item.cx);
        w_y    = $signed(i_item.cy);
        w_ang  = $signed(i_item.ang);
        w_dx   = w_y >>> STEP;
        w_dy   = w_x >>> STEP;
        // rotate toward the x axis
        if (STEP < ANGLE_STEPS) begin
            if (!w_y[CORDIC_W-1]) begin
                n_item.cx  = w_x + w_dx;
                n_item.cy  = w_y - w_dy;
                n_item.ang = w_ang + ATAN;
            end else begin
                n_item.cx  = w_x - w_dx;
                n_item.cy  = w_y + w_dy;
                n_item.ang = w_ang - ATAN;
            end
        end
        // restoring divide: the only nonzero dividend bit below the start is |c| bit 0
        w_bx = (STEP == 0) ? i_item.x[0] : 1'b0;
        w_by = (STEP == 0) ? i_item.y[0] : 1'b0;
        w_tx = {i_item.remx, w_bx};
        w_ty = {i_item.remy, w_by};
        if (w_tx >= {1'b0, i_item.root}) begin
            n_item.remx = 32'(w_tx - {1'b0, i_item.root});
            n_item.qx   = {i_item.qx[29:0], 1'b1};
        end else begin
            n_item.remx = w_tx[31:0];
            n_item.qx   = {i_item.qx[29:0], 1'b0};
        end
        if (w_ty >= {1'b0, i_item.root}) begin
            n_item.remy = 32'(w_ty - {1'b0, i_item.root});
            n_item.qy   = {i_item.qy[29:0], 1'b1};
        end else begin
            n_item.remy = w_ty[31:0];
            n_item.qy   = {i_item.qy[29:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/fpp_mul_cell.sv =====
// Rounded, saturating multiply-add cell: partial products, round, add and clamp.
`timescale 1ns / 1ps
module fpp_mul_cell import fpp_pkg::*; #(
    parameter int SHIFT = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_item              i_item,
    input  logic signed [63:0] i_wide,
    input  logic signed [32:0] i_narrow,
    input  logic signed [31:0] i_add,
    output logic               o_valid,
    output t_item              o_item,
    output logic signed [63:0] o_res
);

    localparam logic [94:0] HALF  = 95'd1 << (SHIFT - 1);
    localparam logic [94:0] LIM95 = 95'd1 << 61;
    localparam logic [61:0] LIM62 = 62'd1 << 61;

    logic [63:0] w_abs_w;
    logic [32:0] w_abs_n;
    logic        w_neg;
    logic [94:0] w_full;
    logic [94:0] w_sh;
    logic [61:0] w_mag;
    logic signed [63:0] w_sum;

    logic               r_vld1, r_vld2, r_vld3;
    t_item              r_item1, r_item2, r_item3;
    logic               r_neg1;
    logic [62:0]        r_pp_lo;
    logic [62:0]        r_pp_hi;
    logic signed [31:0] r_add1, r_add2;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_res;
    logic signed [63:0] n_prod;

    // Split the wide magnitude in two 31-bit halves
    always_comb begin
        w_neg   = i_wide[63] ^ i_narrow[32];
        w_abs_w = i_wide[63] ? 64'(-i_wide) : 64'(i_wide);
        w_abs_n = i_narrow[32] ? 33'(-i_narrow) : 33'(i_narrow);
    end

    // Sum partial products, round half away from zero, saturate
    always_comb begin
        w_full = {1'b0, r_pp_hi, 31'd0} + {32'd0, r_pp_lo} + HALF;
        w_sh   = w_full >> SHIFT;
        w_mag  = (w_sh > LIM95) ? LIM62 : w_sh[61:0];
        n_prod = r_neg1 ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag});
        w_sum  = r_prod + 64'(r_add2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item1 <= i_item;
            r_neg1  <= w_neg;
            r_add1  <= i_add;
            r_pp_lo <= 63'(w_abs_w[30:0]) * 63'(w_abs_n[31:0]);
            r_pp_hi <= 63'(w_abs_w[61:31]) * 63'(w_abs_n[31:0]);
            r_item2 <= r_item1;
            r_add2  <= r_add1;
            r_prod  <= n_prod;
            r_item3 <= r_item2;
            r_res   <= f_clamp(w_sum);
        end
    end

    assign o_valid = r_vld3;
    assign o_item  = r_item3;
    assign o_res   = r_res;

endmodule

// ===== hw/rtl/fpp_checker.sv =====
// Port-level checks for the fisheye point projector, bound to the top level.
`timescale 1ns / 1ps
module fpp_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result visible right after reset");

    // input only stalls when results are queued
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output queue");

endmodule

bind fisheye_point_projection_core fpp_port_checks u_fpp_port_checks (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
